// ===== rtl/core/fats_pkg.sv =====
package fats_pkg;

  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int TAG_BITS_DEF = 18;
  localparam int LINES_DEF    = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic ACC_READ             = 1'b0;
  localparam logic ACC_WRITE            = 1'b1;
  localparam logic POLICY_WRITE_THROUGH = 1'b0;
  localparam logic POLICY_WRITE_BACK    = 1'b1;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_DROPPED = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_UPD
  } bk_state_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== rtl/core/fats_if.sv =====
interface fats_in_if
  import fats_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface fats_out_if
  import fats_pkg::*;
();
  logic             valid;
  logic             ready;
  outcome_t         outcome;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] memory_read_total;
  logic [CNT_W-1:0] memory_write_total;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output memory_read_total, output memory_write_total, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input memory_read_total, input memory_write_total, output ready);
endinterface

interface fats_cfg_if;
  logic valid;
  logic ready;
  logic policy_sel;

  modport source (output valid, output policy_sel, input ready);
  modport sink   (input valid, input policy_sel, output ready);
endinterface

// ===== rtl/core/fully_associative_tag_store_core.sv =====
// Fully associative tag store with hit/miss accounting. Each access item gives its mode
// and byte address; the top TAG_BITS address bits are compared in parallel against all
// filled lines. A hit counts a hit (and a memory write for a write under write-through);
// a miss fills the next free line and counts a miss and a memory read; a miss with all
// LINES lines filled is reported as dropped and changes nothing. Every result carries all
// four wrapping 32-bit totals. The tag lines are flops, filled in order, with no reset.
// The lookup engine handles each item in a compare state, then an update state, and takes
// no new item until it is through with the last; update stalls while a result waits.
// A 2-entry queue between input side and lookup engine lets each side stall on its own.
// The policy register (cfg, 0 write-through, 1 write-back) is always ready and must be
// written only while the block is idle.
module fully_associative_tag_store_core
  import fats_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF,
  parameter int LINES    = LINES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fats_in_if.sink    in_chan,
  fats_out_if.source out_chan,
  fats_cfg_if.sink   cfg_chan
);

  q_stat_t           q_stat;
  q_ctrl_t           q_ctrl;
  logic              q_push;
  logic              q_pop;
  logic [TAG_BITS:0] q_wdata;
  logic [TAG_BITS:0] q_rdata;

  assign cfg_chan.ready = 1'b1;
  assign q_ctrl         = '{push: q_push, pop: q_pop};

  fats_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_mode        (in_chan.mode),
    .in_address     (in_chan.address),
    .cfg_valid      (cfg_chan.valid),
    .cfg_policy_sel (cfg_chan.policy_sel),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  fats_queue #(
    .WIDTH (TAG_BITS + 1)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  fats_back #(
    .TAG_BITS (TAG_BITS),
    .LINES    (LINES)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_stat                 (q_stat),
    .q_rdata                (q_rdata),
    .q_pop                  (q_pop),
    .out_valid              (out_chan.valid),
    .out_ready              (out_chan.ready),
    .out_outcome            (out_chan.outcome),
    .out_hit_total          (out_chan.hit_total),
    .out_miss_total         (out_chan.miss_total),
    .out_memory_read_total  (out_chan.memory_read_total),
    .out_memory_write_total (out_chan.memory_write_total)
  );

endmodule

// ===== rtl/core/fats_front.sv =====
module fats_front
  import fats_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              cfg_valid,
  input  logic              cfg_policy_sel,
  input  q_stat_t           q_stat,
  output logic              q_push,
  output logic [TAG_BITS:0] q_wdata
);

  logic policy_r;
  logic policy_nxt;

  always_comb begin
    policy_nxt = policy_r;
    if (cfg_valid) begin
      policy_nxt = cfg_policy_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_WRITE_THROUGH;
    end else begin
      policy_r <= policy_nxt;
    end
  end

  // item carries the tag and whether a hit would count a memory write
  assign in_ready = q_stat.not_full;
  assign q_push   = in_valid && q_stat.not_full;
  assign q_wdata  = {(in_mode == ACC_WRITE) && (policy_r == POLICY_WRITE_THROUGH),
                     in_address[ADDR_W-1 -: TAG_BITS]};

endmodule

// ===== rtl/core/fats_queue.sv =====
module fats_queue
  import fats_pkg::*;
#(
  parameter int WIDTH = TAG_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_ctrl_t          ctrl,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]   mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctrl.push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (ctrl.pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (ctrl.push && !ctrl.pop) begin
      count_nxt = count_r + CNT_W_Q'(1);
    end else if (!ctrl.push && ctrl.pop) begin
      count_nxt = count_r - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata          = mem[rd_ptr_r];
  assign stat.not_full  = (count_r != CNT_W_Q'(QUEUE_DEPTH));
  assign stat.not_empty = (count_r != '0);

endmodule

// ===== rtl/core/fats_back.sv =====
module fats_back
  import fats_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF,
  parameter int LINES    = LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  logic [TAG_BITS:0] q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output outcome_t          out_outcome,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_miss_total,
  output logic [CNT_W-1:0]  out_memory_read_total,
  output logic [CNT_W-1:0]  out_memory_write_total
);

  localparam int FILL_W = $clog2(LINES + 1);
  localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;

  bk_state_t state_r, state_nxt;

  logic [TAG_BITS-1:0] tag_entries [LINES];
  logic [FILL_W-1:0]   filled_r, filled_nxt;
  logic [CNT_W-1:0]    hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]    miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]    wr_cnt_r, wr_cnt_nxt;

  logic [TAG_BITS-1:0] tag_r;
  logic                wr_thru_r;
  logic                hit_r;
  logic [LINES-1:0]    match;
  logic                full;

  logic                out_valid_r, out_valid_nxt;
  outcome_t            outcome_r, outcome_nxt;

  logic                fire;
  logic                fill_en;

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      match[i] = (FILL_W'(i) < filled_r) && (tag_entries[i] == tag_r);
    end
  end

  assign full = (filled_r == FILL_W'(LINES));
  assign fire = (state_r == BK_UPD) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          state_nxt = BK_CMP;
        end
      end
      BK_CMP: begin
        state_nxt = BK_UPD;
      end
      BK_UPD: begin
        if (fire) begin
          state_nxt = q_stat.not_empty ? BK_CMP : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop   = 1'b0;
    fill_en = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop = q_stat.not_empty;
      end
      BK_CMP: begin
        q_pop = 1'b0;
      end
      BK_UPD: begin
        q_pop   = fire && q_stat.not_empty;
        fill_en = fire && !hit_r && !full;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    filled_nxt    = filled_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    outcome_nxt   = outcome_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (hit_r) begin
        outcome_nxt = OUT_HIT;
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
        if (wr_thru_r) begin
          wr_cnt_nxt = wr_cnt_r + CNT_W'(1);
        end
      end else if (!full) begin
        outcome_nxt  = OUT_FILL;
        filled_nxt   = filled_r + FILL_W'(1);
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
        rd_cnt_nxt   = rd_cnt_r + CNT_W'(1);
      end else begin
        outcome_nxt = OUT_DROPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      filled_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag_r     <= q_rdata[TAG_BITS-1:0];
      wr_thru_r <= q_rdata[TAG_BITS];
    end
    if (state_r == BK_CMP) begin
      hit_r <= |match;
    end
    outcome_r <= outcome_nxt;
  end

  always_ff @(posedge clk) begin
    if (fill_en) begin
      tag_entries[filled_r[IDX_W-1:0]] <= tag_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_outcome            = outcome_r;
  assign out_hit_total          = hit_cnt_r;
  assign out_miss_total         = miss_cnt_r;
  assign out_memory_read_total  = rd_cnt_r;
  assign out_memory_write_total = wr_cnt_r;

endmodule
